/* rtl/rmu_pkg.sv */
// rmu_pkg: shared types and constants for the running median unit
// depends on nothing; imported by every module of the block

package rmu_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int MEDIAN_W     = 17;
  localparam int COUNT_W      = 7;
  localparam int DEF_CAPACITY = 64;
  // cells per group in the first level of the median select tree
  localparam int GROUP_SIZE   = 8;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       restart;
  } in_word_t;

  typedef struct packed {
    logic signed [MEDIAN_W-1:0] median_twice;
    logic        [COUNT_W-1:0]  stored_count;
    logic                       dropped;
  } out_word_t;

  // broadcast to every cell of the sorted chain
  typedef struct packed {
    logic                       insert;
    logic signed [SAMPLE_W-1:0] sample;
  } chain_ctl_t;

endpackage

/* rtl/running_median_unit.sv */
// running_median_unit: running median over a sorted chain of sample cells
// depends on rmu_pkg, rmu_cell and rmu_median_sel
//
// Usage: samples arrive on in_word_i (sample, restart) with in_valid_i and
// in_stall_o; results leave on out_word_o (median_twice, stored_count,
// dropped) with out_valid_o and out_stall_i. A word moves on a clock edge
// where valid is high and stall is low. Every input word yields exactly one
// result word, in order.
// The store is a row of CAPACITY cells kept in ascending order. An accepted
// sample is inserted in parallel: every larger cell shifts one place right
// while the slot at the insertion point takes the sample. restart empties
// the store before its sample goes in; a sample that finds the store full
// is dropped and the previous median is given again.
// Throughput is one word per cycle while out_stall_i holds back no result.
// Each result passes the insert, then a two-level registered select that picks
// the middle cells and adds them.
// Reset empties the store and the pipeline at once; no clearing pass.
// While out_stall_i holds back a waiting result, the whole pipeline holds
// and in_stall_o is high.

module running_median_unit import rmu_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic                       adv, accept, full_now;
  logic [CW-1:0]              count_q, count_d, base_count;
  chain_ctl_t                 ctl;
  logic                       occupied [CAPACITY];
  logic                       gts      [CAPACITY];
  logic signed [SAMPLE_W-1:0] vals     [CAPACITY];
  logic signed [MEDIAN_W-1:0] sum;

  logic          p1_valid_q, p2_valid_q, out_valid_q;
  logic          p1_drop_q, p2_drop_q, out_drop_q;
  logic [CW-1:0] p2_count_q, out_count_q;

  // pipeline moves unless a finished word is held back
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  assign base_count = in_word_i.restart ? '0 : count_q;
  assign full_now   = (base_count == CW'(CAPACITY));

  assign ctl.insert = accept && !full_now;
  assign ctl.sample = in_word_i.sample;

  always_comb begin
    count_d = count_q;
    if (accept && !full_now) begin
      count_d = base_count + CW'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occupied[i] = !in_word_i.restart && (CW'(i) < count_q);
    if (i == 0) begin : g_head
      rmu_cell u_cell (
        .clk_i      (clk_i),
        .ctl_i      (ctl),
        .occupied_i (occupied[i]),
        .left_gt_i  (1'b0),
        .left_val_i (ctl.sample),
        .val_o      (vals[i]),
        .gt_o       (gts[i])
      );
    end else begin : g_body
      rmu_cell u_cell (
        .clk_i      (clk_i),
        .ctl_i      (ctl),
        .occupied_i (occupied[i]),
        .left_gt_i  (gts[i-1]),
        .left_val_i (vals[i-1]),
        .val_o      (vals[i]),
        .gt_o       (gts[i])
      );
    end
  end

  rmu_median_sel #(
    .CAPACITY (CAPACITY)
  ) u_sel (
    .clk_i   (clk_i),
    .en_i    (adv),
    .vals_i  (vals),
    .count_i (count_q),
    .sum_o   (sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (adv) begin
        p1_valid_q  <= in_valid_i;
        p2_valid_q  <= p1_valid_q;
        out_valid_q <= p2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_drop_q   <= full_now;
      p2_drop_q   <= p1_drop_q;
      p2_count_q  <= count_q;
      out_drop_q  <= p2_drop_q;
      out_count_q <= p2_count_q;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_word_o.median_twice = sum;
  assign out_word_o.stored_count = COUNT_W'(out_count_q);
  assign out_word_o.dropped      = out_drop_q;

endmodule

/* rtl/rmu_cell.sv */
// rmu_cell: one slot of the sorted insertion chain
// depends on rmu_pkg; a row of these lives in running_median_unit

module rmu_cell import rmu_pkg::*; (
  input  logic                       clk_i,
  input  chain_ctl_t                 ctl_i,
  input  logic                       occupied_i,
  input  logic                       left_gt_i,
  input  logic signed [SAMPLE_W-1:0] left_val_i,
  output logic signed [SAMPLE_W-1:0] val_o,
  output logic                       gt_o
);

  logic signed [SAMPLE_W-1:0] val_q, val_d;

  // this slot holds a sample larger than the incoming one
  assign gt_o  = occupied_i && (val_q > ctl_i.sample);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.insert && (gt_o || !occupied_i)) begin
      // shift in from the left while the left neighbor is larger, else take the sample
      val_d = left_gt_i ? left_val_i : ctl_i.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

/* rtl/rmu_median_sel.sv */
// rmu_median_sel: two-stage registered select of the middle cells and their sum
// depends on rmu_pkg; reads the cell values of the chain in running_median_unit

module rmu_median_sel import rmu_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [SAMPLE_W-1:0]         vals_i [CAPACITY],
  input  logic [$clog2(CAPACITY+1)-1:0]      count_i,
  output logic signed [MEDIAN_W-1:0]         sum_o
);

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [CW-1:0]         lo_idx, hi_idx;
  logic [SAMPLE_W-1:0]   part_lo_d [GROUPS];
  logic [SAMPLE_W-1:0]   part_hi_d [GROUPS];
  logic [SAMPLE_W-1:0]   part_lo_q [GROUPS];
  logic [SAMPLE_W-1:0]   part_hi_q [GROUPS];
  logic [SAMPLE_W-1:0]   lo_val, hi_val;
  logic signed [MEDIAN_W-1:0] sum_q;

  // lower and upper middle positions; equal for an odd count
  assign lo_idx = (count_i - CW'(1)) >> 1;
  assign hi_idx = count_i >> 1;

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      part_lo_d[g] = '0;
      part_hi_d[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (g * GROUP_SIZE + j < CAPACITY) begin
          if (CW'(g * GROUP_SIZE + j) == lo_idx) begin
            part_lo_d[g] = part_lo_d[g] | vals_i[g * GROUP_SIZE + j];
          end
          if (CW'(g * GROUP_SIZE + j) == hi_idx) begin
            part_hi_d[g] = part_hi_d[g] | vals_i[g * GROUP_SIZE + j];
          end
        end
      end
    end
  end

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int g = 0; g < GROUPS; g++) begin
      lo_val = lo_val | part_lo_q[g];
      hi_val = hi_val | part_hi_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      part_lo_q <= part_lo_d;
      part_hi_q <= part_hi_d;
      sum_q     <= {lo_val[SAMPLE_W-1], lo_val} + {hi_val[SAMPLE_W-1], hi_val};
    end
  end

  assign sum_o = sum_q;

endmodule

/* rtl/rmu_checker.sv */
// rmu_checker: port-level checks for running_median_unit, bound to the top level
// depends on rmu_pkg and running_median_unit

module rmu_checker import rmu_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // input is held off only behind a waiting result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with no result waiting");

  // a dropped sample only happens on a full store
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.dropped |->
      out_word_o.stored_count == COUNT_W'(CAPACITY))
    else $error("drop reported on a store that is not full");

  // every result follows at least one kept sample
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.stored_count != '0)
    else $error("result with an empty store");

  // odd count means a single middle sample, so no fraction bit
  a_odd_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.stored_count[0] |-> !out_word_o.median_twice[0])
    else $error("fraction bit set for an odd count");

endmodule

bind running_median_unit rmu_checker #(.CAPACITY(CAPACITY)) u_rmu_checker (.*);
